[sv/exchange_sort_engine_defines.svh]
// ----------------------------------------------------------------------------
// exchange_sort_engine_defines
// Assertion macros used by the checker file of the sort engine.
// ----------------------------------------------------------------------------
`ifndef EXCHANGE_SORT_ENGINE_DEFINES_SVH
`define EXCHANGE_SORT_ENGINE_DEFINES_SVH

// Same-cycle implication, clocked on clk_i, off while rst_ni is low
`define ESE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, off while rst_ni is low
`define ESE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/ese_pkg.sv]
// ----------------------------------------------------------------------------
// ese_pkg
// Types and constants shared by the exchange sort engine modules.
// ----------------------------------------------------------------------------
package ese_pkg;

  localparam int VALUE_W       = 32;
  localparam int DEPTH_DEF     = 64;
  localparam int IN_Q_ENTRIES  = 2;
  localparam int RES_Q_ENTRIES = 4;
  localparam int RES_CNT_W     = $clog2(RES_Q_ENTRIES + 1);

  // Classified item handed from the front to the back
  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      last;
    logic                      keep;
  } item_t;

  // One sorted result waiting for the consumer
  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      eol;
    logic                      ovf;
  } result_t;

  // Back-end sequencer states
  typedef enum logic [2:0] {
    ST_FILL,
    ST_RDI,
    ST_LDI,
    ST_SCAN,
    ST_WRI,
    ST_EMIT
  } state_e;

endpackage

[sv/ese_fifo.sv]
// ----------------------------------------------------------------------------
// ese_fifo
// Small register queue with count, used between the pipeline parts.
// ----------------------------------------------------------------------------
module ese_fifo #(
  parameter int WIDTH   = 8,
  parameter int ENTRIES = 2
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             push_i,
  input  logic [WIDTH-1:0]                 wdata_i,
  input  logic                             pop_i,
  output logic [WIDTH-1:0]                 rdata_o,
  output logic                             full_o,
  output logic                             empty_o,
  output logic [$clog2(ENTRIES+1)-1:0]     count_o
);

  localparam int PTR_W = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);

  logic [WIDTH-1:0] slot_q [ENTRIES];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(ENTRIES));
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;
  assign rdata_o = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Store the pushed item
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= wdata_i;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

endmodule

[sv/ese_front.sv]
// ----------------------------------------------------------------------------
// ese_front
// Accepts list items, marks each as kept or dropped by list position.
// ----------------------------------------------------------------------------
module ese_front #(
  parameter int DEPTH = ese_pkg::DEPTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push_i,
  input  logic signed [ese_pkg::VALUE_W-1:0]  value_i,
  input  logic                                is_last_i,
  input  logic                                q_full_i,
  output logic                                full_o,
  output logic                                q_push_o,
  output ese_pkg::item_t                      q_item_o
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0] fcnt_q, fcnt_d;
  logic             accept;

  assign full_o   = q_full_i;
  assign accept   = push_i && !q_full_i;
  assign q_push_o = accept;

  // Classify: keep while the list still fits the buffer
  always_comb begin
    q_item_o.value = value_i;
    q_item_o.last  = is_last_i;
    q_item_o.keep  = (fcnt_q < CNT_W'(DEPTH));
  end

  // Track list position, restart after the last item
  always_comb begin
    fcnt_d = fcnt_q;
    if (accept) begin
      if (is_last_i) begin
        fcnt_d = '0;
      end else if (q_item_o.keep) begin
        fcnt_d = fcnt_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fcnt_q <= '0;
    end else begin
      fcnt_q <= fcnt_d;
    end
  end

endmodule

[sv/ese_back.sv]
// ----------------------------------------------------------------------------
// ese_back
// Buffers a list, sorts it in place by exchange sort, emits it in order.
// ----------------------------------------------------------------------------
module ese_back #(
  parameter int DEPTH = ese_pkg::DEPTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            q_empty_i,
  input  ese_pkg::item_t                  q_item_i,
  output logic                            q_pop_o,
  input  logic [ese_pkg::RES_CNT_W-1:0]   res_count_i,
  output logic                            res_push_o,
  output ese_pkg::result_t                res_item_o
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int RCW   = ese_pkg::RES_CNT_W;

  ese_pkg::state_e state_q, state_d;

  logic signed [ese_pkg::VALUE_W-1:0] mem [DEPTH];
  logic signed [ese_pkg::VALUE_W-1:0] rd_q;
  logic signed [ese_pkg::VALUE_W-1:0] cur_q, cur_d;
  logic signed [ese_pkg::VALUE_W-1:0] wdata;
  logic [IDX_W-1:0] waddr, raddr;
  logic             we, re;

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [IDX_W-1:0] i_q, i_d;
  logic [CNT_W-1:0] j_q, j_d;
  logic [CNT_W-1:0] k_q, k_d;
  logic             ovf_q, ovf_d;
  logic             pend_q, pend_d;
  logic             pend_eol_q, pend_eol_d;
  logic             pend_ovf_q, pend_ovf_d;

  logic fill_take, fill_last, scan_end, last_pair, credit, emit_go, emit_last, swap;

  // Status terms
  assign fill_take = (state_q == ese_pkg::ST_FILL) && !q_empty_i;
  assign fill_last = fill_take && q_item_i.last;
  assign scan_end  = (j_q == cnt_q);
  assign last_pair = ((CNT_W'(i_q) + CNT_W'(2)) == cnt_q);
  assign credit    = ((res_count_i + RCW'(pend_q)) < RCW'(ese_pkg::RES_Q_ENTRIES));
  assign emit_go   = (state_q == ese_pkg::ST_EMIT) && credit;
  assign emit_last = ((k_q + CNT_W'(1)) == cnt_q);
  assign swap      = (cur_q > rd_q);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ese_pkg::ST_FILL: begin
        if (fill_last) begin
          state_d = (cnt_q == '0) ? ese_pkg::ST_EMIT : ese_pkg::ST_RDI;
        end
      end
      ese_pkg::ST_RDI:  state_d = ese_pkg::ST_LDI;
      ese_pkg::ST_LDI:  state_d = ese_pkg::ST_SCAN;
      ese_pkg::ST_SCAN: begin
        if (scan_end) begin
          state_d = ese_pkg::ST_WRI;
        end
      end
      ese_pkg::ST_WRI: begin
        state_d = last_pair ? ese_pkg::ST_EMIT : ese_pkg::ST_RDI;
      end
      ese_pkg::ST_EMIT: begin
        if (emit_go && emit_last) begin
          state_d = ese_pkg::ST_FILL;
        end
      end
      default: state_d = ese_pkg::ST_FILL;
    endcase
  end

  // Datapath control and register updates
  always_comb begin
    q_pop_o    = 1'b0;
    we         = 1'b0;
    waddr      = '0;
    wdata      = cur_q;
    re         = 1'b0;
    raddr      = '0;
    cnt_d      = cnt_q;
    ovf_d      = ovf_q;
    i_d        = i_q;
    j_d        = j_q;
    k_d        = '0;
    cur_d      = cur_q;
    pend_d     = 1'b0;
    pend_eol_d = pend_eol_q;
    pend_ovf_d = pend_ovf_q;
    unique case (state_q)
      ese_pkg::ST_FILL: begin
        // Store kept items, note dropped ones
        if (fill_take) begin
          q_pop_o = 1'b1;
          if (q_item_i.keep) begin
            we    = 1'b1;
            waddr = IDX_W'(cnt_q);
            wdata = q_item_i.value;
            cnt_d = cnt_q + CNT_W'(1);
          end else begin
            ovf_d = 1'b1;
          end
          i_d = '0;
          j_d = CNT_W'(1);
        end
      end
      ese_pkg::ST_RDI: begin
        // Fetch the head of the pass
        re    = 1'b1;
        raddr = i_q;
      end
      ese_pkg::ST_LDI: begin
        // Latch the head, fetch the first later entry
        cur_d = rd_q;
        re    = 1'b1;
        raddr = IDX_W'(j_q);
        j_d   = j_q + CNT_W'(1);
      end
      ese_pkg::ST_SCAN: begin
        // Compare, swap the larger into the later slot, fetch the next
        if (swap) begin
          we    = 1'b1;
          waddr = IDX_W'(j_q - CNT_W'(1));
          wdata = cur_q;
          cur_d = rd_q;
        end
        if (!scan_end) begin
          re    = 1'b1;
          raddr = IDX_W'(j_q);
          j_d   = j_q + CNT_W'(1);
        end
      end
      ese_pkg::ST_WRI: begin
        // Retire the head of the pass
        we    = 1'b1;
        waddr = i_q;
        wdata = cur_q;
        i_d   = i_q + IDX_W'(1);
        j_d   = CNT_W'(i_q) + CNT_W'(2);
      end
      ese_pkg::ST_EMIT: begin
        // Read out in order while the result queue has room
        k_d = k_q;
        if (emit_go) begin
          re         = 1'b1;
          raddr      = IDX_W'(k_q);
          k_d        = k_q + CNT_W'(1);
          pend_d     = 1'b1;
          pend_eol_d = emit_last;
          pend_ovf_d = ovf_q;
          if (emit_last) begin
            cnt_d = '0;
            ovf_d = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  // Forward the fetched element into the result queue
  assign res_push_o       = pend_q;
  assign res_item_o.value = rd_q;
  assign res_item_o.eol   = pend_eol_q;
  assign res_item_o.ovf   = pend_ovf_q;

  // Element buffer: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_q <= mem[raddr];
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    i_q        <= i_d;
    j_q        <= j_d;
    pend_eol_q <= pend_eol_d;
    pend_ovf_q <= pend_ovf_d;
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ese_pkg::ST_FILL;
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
      k_q     <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ovf_q   <= ovf_d;
      k_q     <= k_d;
      pend_q  <= pend_d;
    end
  end

endmodule

[sv/exchange_sort_engine.sv]
// ----------------------------------------------------------------------------
// exchange_sort_engine
// Collects a list of signed values, sorts it ascending, returns it in order.
//
//   channel   direction  handshake         payload
//   input     in         push / full       value_i, is_last_i
//   result    out        pop / empty       sorted_value_o, end_of_list_o,
//                                          overflow_o
//
// A list of stored items is loaded, sorted with the single compare unit and
// its buffer port, and then read out.
// Items of the next list are taken into a two-entry queue while a list is
// sorted; full holds once that queue fills. A stalled consumer holds the
// read-out only; rst_ni clears all control state at once.
// ----------------------------------------------------------------------------
module exchange_sort_engine #(
  parameter int DEPTH = ese_pkg::DEPTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               push,
  output logic                               full,
  input  logic signed [ese_pkg::VALUE_W-1:0] value_i,
  input  logic                               is_last_i,
  output logic                               empty,
  input  logic                               pop,
  output logic signed [ese_pkg::VALUE_W-1:0] sorted_value_o,
  output logic                               end_of_list_o,
  output logic                               overflow_o
);

  localparam int ITEM_W = $bits(ese_pkg::item_t);
  localparam int RES_W  = $bits(ese_pkg::result_t);

  ese_pkg::item_t                 fr_item, bk_item;
  ese_pkg::result_t               bk_res, out_res;
  logic [ITEM_W-1:0]              bk_item_bits;
  logic [RES_W-1:0]               out_res_bits;
  logic                           fr_push, q_full, q_empty, q_pop;
  logic                           res_push;
  logic [ese_pkg::RES_CNT_W-1:0]  res_count;

  // Front: accept and classify
  ese_front #(
    .DEPTH (DEPTH)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .value_i   (value_i),
    .is_last_i (is_last_i),
    .q_full_i  (q_full),
    .full_o    (full),
    .q_push_o  (fr_push),
    .q_item_o  (fr_item)
  );

  // Queue between front and back
  ese_fifo #(
    .WIDTH   (ITEM_W),
    .ENTRIES (ese_pkg::IN_Q_ENTRIES)
  ) u_in_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fr_push),
    .wdata_i (fr_item),
    .pop_i   (q_pop),
    .rdata_o (bk_item_bits),
    .full_o  (q_full),
    .empty_o (q_empty),
    .count_o ()
  );

  assign bk_item = ese_pkg::item_t'(bk_item_bits);

  // Back: buffer, sort, read out
  ese_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_item_i    (bk_item),
    .q_pop_o     (q_pop),
    .res_count_i (res_count),
    .res_push_o  (res_push),
    .res_item_o  (bk_res)
  );

  // Result queue toward the consumer
  ese_fifo #(
    .WIDTH   (RES_W),
    .ENTRIES (ese_pkg::RES_Q_ENTRIES)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (bk_res),
    .pop_i   (pop),
    .rdata_o (out_res_bits),
    .full_o  (),
    .empty_o (empty),
    .count_o (res_count)
  );

  assign out_res        = ese_pkg::result_t'(out_res_bits);
  assign sorted_value_o = out_res.value;
  assign end_of_list_o  = out_res.eol;
  assign overflow_o     = out_res.ovf;

endmodule

[sv/ese_checker.sv]
// ----------------------------------------------------------------------------
// ese_checker
// Port-level checks of the sort engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "exchange_sort_engine_defines.svh"

module ese_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               push,
  input logic                               full,
  input logic signed [ese_pkg::VALUE_W-1:0] value_i,
  input logic                               is_last_i,
  input logic                               empty,
  input logic                               pop,
  input logic signed [ese_pkg::VALUE_W-1:0] sorted_value_o,
  input logic                               end_of_list_o,
  input logic                               overflow_o
);

  logic                               out_take, in_take;
  logic                               mid_q;
  logic signed [ese_pkg::VALUE_W-1:0] prev_val_q;
  logic                               prev_ovf_q;

  assign out_take = pop && !empty;
  assign in_take  = push && !full;

  // Remember the last result taken inside the current list
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_q      <= 1'b0;
      prev_val_q <= '0;
      prev_ovf_q <= 1'b0;
    end else if (out_take) begin
      mid_q      <= !end_of_list_o;
      prev_val_q <= sorted_value_o;
      prev_ovf_q <= overflow_o;
    end
  end

  // A waiting result holds until taken
  `ESE_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(sorted_value_o) && $stable(end_of_list_o) && $stable(overflow_o), "result changed while waiting")

  // Results within a list come out in ascending order
  `ESE_ASSERT_NOW(a_ascending, out_take && mid_q, sorted_value_o >= prev_val_q, "results out of order")

  // The overflow flag is the same on every result of a list
  `ESE_ASSERT_NOW(a_ovf_same, out_take && mid_q, overflow_o == prev_ovf_q, "overflow flag changed within a list")

  // An accepted item carries known fields
  `ESE_ASSERT_NOW(a_in_known, in_take, !$isunknown(value_i) && !$isunknown(is_last_i), "accepted item has unknown fields")

endmodule

bind exchange_sort_engine ese_checker u_ese_checker (.*);
